// ===== design/tabular_q_learning_engine_unit_macros.svh =====
// Assertion helpers shared by the engine files.
`ifndef TABULAR_Q_LEARNING_ENGINE_UNIT_MACROS_SVH
`define TABULAR_Q_LEARNING_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TQLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TQLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tqle_pkg.sv =====
package tqle_pkg;

  // Fixed-point format of rewards and table values.
  localparam int FRAC_BITS = 12;
  localparam int RATE_W    = 13;
  localparam int THRESH_W  = 17;

  // Random source: 16-bit Galois LFSR.
  localparam logic [15:0] LFSR_SEED = 16'd44257;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // Register reset values.
  localparam logic [RATE_W-1:0]   LEARN_RATE_RESET = 13'd410;
  localparam logic [RATE_W-1:0]   DISCOUNT_RESET   = 13'd3686;
  localparam logic [THRESH_W-1:0] THRESH_RESET     = 17'd6554;

  // Register indexes on the configuration channel.
  localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

  // Command codes.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CHOOSE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CELL = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;

  // Board checks from the decoder.
  typedef struct packed {
    logic bad;
    logic full;
  } board_flags_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DRAW,
    S_MOD,
    S_PICK,
    S_READ,
    S_CUR,
    S_INNER,
    S_MLO,
    S_MHI,
    S_SUM,
    S_RESULT
  } state_t;

  // Power of three, evaluated at elaboration.
  function automatic int unsigned pow3(input int unsigned n);
    int unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

endpackage

// ===== design/tqle_board_decode.sv =====
module tqle_board_decode
  import tqle_pkg::*;
#(
  parameter int BOARD_CELLS = 9,
  parameter int AW          = 18
) (
  input  logic [17:0]            board,
  output logic [AW-1:0]          base,
  output logic [BOARD_CELLS-1:0] free,
  output board_flags_t           flags
);

  // Weight of one cell in the table index: 3^i * BOARD_CELLS.
  function automatic logic [AW-1:0] cell_weight(input int unsigned i);
    return AW'(pow3(i) * BOARD_CELLS);
  endfunction

  // Each cell contributes 0, one or two weights; all terms are independent.
  always_comb begin
    logic [AW-1:0] acc;
    logic          bad;
    logic [1:0]    c;
    acc = '0;
    bad = 1'b0;
    for (int i = 0; i < BOARD_CELLS; i++) begin
      c       = board[2*i +: 2];
      free[i] = (c == 2'd0);
      if (c == 2'd3) begin
        bad = 1'b1;
      end
      if (c == 2'd1) begin
        acc = acc + cell_weight(i);
      end else if (c == 2'd2) begin
        acc = acc + (cell_weight(i) << 1);
      end
    end
    base       = acc;
    flags.bad  = bad;
    flags.full = ~|free;
  end

endmodule

// ===== design/tabular_q_learning_engine_unit.sv =====
// Tabular Q-learning engine with an epsilon-greedy action chooser.
// Input channel s_axis_*: one transaction is one command. tuser carries the
// command (0 update, 1 choose); tdata carries board, action, reward and
// next_board. Output channel m_axis_*: exactly one result per command.
// Configuration channel cfg_*: always ready; index 0 learn rate, 1 discount,
// 2 explore threshold, other indexes are ignored. Write it only while idle.
// After reset the table is swept to zero, one entry per cycle, covering all
// 3^BOARD_CELLS * BOARD_CELLS entries (177147 by default); the input is not
// ready during that sweep. One table with one read and one write port and one
// shared multiplier carry all the work, so one command is in flight at a time.
// Steps from acceptance to the result register, default of nine cells:
//   update: decode, nine table reads plus the current value,
//   three multiplier passes, inner sum, write-back, result; choose, greedy:
//   decode, draw, table reads, result; choose, explore: decode, draw, then
//   modulo (reciprocal multiply) and pick per LFSR redraw, result; bad cell
//   code or full board: decode, result. Input is ready after the result loads.
// The result waits in an output register; a stalled receiver holds it and
// the next command is accepted but finishes only once that slot is free.
`include "tabular_q_learning_engine_unit_macros.svh"

module tabular_q_learning_engine_unit
  import tqle_pkg::*;
#(
  parameter int BOARD_CELLS = 9,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // Command input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,  // board[17:0], action[21:18],
                                             // reward[37:22], next_board[55:38]
  input  logic                s_axis_tuser,  // command[0]
  // Result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // chosen_action[3:0], new_value[19:4],
                                             // zero pad[23:20]
  output logic [3:0]          m_axis_tuser,  // action_valid[0], explored[1],
                                             // status[3:2]
  // Configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [THRESH_W-1:0] cfg_data
);

  localparam int VW      = VALUE_WIDTH;
  localparam int Q_DEPTH = pow3(BOARD_CELLS) * BOARD_CELLS;
  localparam int AW      = $clog2(Q_DEPTH);
  localparam int CW      = $clog2(BOARD_CELLS);
  localparam int KW      = $clog2(BOARD_CELLS + 1);
  // Exact width of reward*2^12 + gamma*maxQ - Q*2^12.
  localparam int IW      = ((VW + RATE_W + 1 > 2*FRAC_BITS + 4) ?
                            VW + RATE_W + 1 : 2*FRAC_BITS + 4) + 2;
  localparam int HW      = IW - 2*FRAC_BITS;
  localparam int MW      = (VW > 2*FRAC_BITS + 1) ? VW : 2*FRAC_BITS + 1;
  localparam int PW      = MW + RATE_W + 1;
  localparam int SW      = ((VW > HW + RATE_W + 1) ? VW : HW + RATE_W + 1) + 2;
  localparam logic signed [SW-1:0] Q_MAX = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] Q_MIN = ~Q_MAX;
  // Reciprocal of the cell count; exact quotient for any 16-bit draw.
  localparam int RECIP_SH = 20;
  localparam int RPW      = 16 + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((1 << RECIP_SH) + BOARD_CELLS - 1) / BOARD_CELLS);

  // LFSR advance with zero reload.
  function automatic logic [15:0] lfsr_step(input logic [15:0] r);
    logic [15:0] s;
    s = (r == 16'd0) ? LFSR_SEED : r;
    return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
  endfunction

  state_t state, state_next;

  // Configuration registers
  logic [RATE_W-1:0]   learn_rate;
  logic [RATE_W-1:0]   discount;
  logic [THRESH_W-1:0] explore_threshold;

  // Captured command
  logic               cmd;
  logic [17:0]        board;
  logic [3:0]         act;
  logic signed [15:0] reward;
  logic [17:0]        next_board;

  // Working registers
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         cur_base;
  logic [AW-1:0]         next_base;
  logic [AW-1:0]         q_addr;
  logic [KW-1:0]         k;
  logic [CW-1:0]         ridx;
  logic                  rd_live;
  logic                  have;
  logic signed [VW-1:0]  best;
  logic [CW-1:0]         pick;
  logic signed [VW-1:0]  cur;
  logic signed [IW-1:0]  inner;
  logic signed [PW-1:0]  prod;
  logic [RATE_W-1:0]     low_part;
  logic [15:0]           lfsr;
  logic [15:0]           quo;

  // Pending result
  logic [3:0]  res_action;
  logic        res_valid;
  logic        res_explored;
  logic [15:0] res_value;
  logic [1:0]  res_status;

  // Table
  logic signed [VW-1:0] qmem [Q_DEPTH];
  logic signed [VW-1:0] rd_q;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic signed [VW-1:0] wr_data;
  logic                 mem_we;

  // Decoded boards
  logic [AW-1:0]          dec_cur_base, dec_next_base;
  logic [BOARD_CELLS-1:0] free, next_free;
  board_flags_t           cur_flags, next_flags;

  tqle_board_decode #(.BOARD_CELLS(BOARD_CELLS), .AW(AW)) u_cur_decode (
    .board (board),
    .base  (dec_cur_base),
    .free  (free),
    .flags (cur_flags)
  );

  tqle_board_decode #(.BOARD_CELLS(BOARD_CELLS), .AW(AW)) u_next_decode (
    .board (next_board),
    .base  (dec_next_base),
    .free  (next_free),
    .flags (next_flags)
  );

  // Combinational helpers
  logic [CW-1:0]        act_sat;
  logic                 consider;
  logic                 take;
  logic [CW-1:0]        pick_c;
  logic                 item_bad;
  logic                 out_load;
  logic [RATE_W-1:0]    mul_a;
  logic signed [MW-1:0] mul_b;
  logic [RPW-1:0]       recip_prod;
  logic [CW-1:0]        rem;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] nv;
  logic                 in_accept;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // Out-of-range actions fall to the last cell.
  assign act_sat = (act >= 4'(BOARD_CELLS)) ? CW'(BOARD_CELLS - 1) : act[CW-1:0];

  // Running maximum: updates scan every cell, choices scan free cells only.
  assign consider = (cmd == CMD_UPDATE) || free[ridx];
  assign take     = rd_live && consider && (!have || (rd_q > best));
  assign pick_c   = take ? ridx : pick;

  assign item_bad = cur_flags.bad || ((cmd == CMD_UPDATE) && next_flags.bad);
  assign out_load = (state == S_RESULT) && (!m_axis_tvalid || m_axis_tready);

  // LFSR modulo the cell count: quotient by reciprocal, then the remainder.
  assign recip_prod = RPW'(lfsr) * RPW'(RECIP);
  assign rem        = CW'(lfsr - quo * 16'(BOARD_CELLS));

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      S_CUR: begin
        mul_a = discount;
        mul_b = MW'(best);
      end
      S_MLO: begin
        mul_a = learn_rate;
        mul_b = MW'(signed'({1'b0, inner[2*FRAC_BITS-1:0]}));
      end
      default: begin
        mul_a = learn_rate;
        mul_b = MW'(signed'(inner[IW-1:2*FRAC_BITS]));
      end
    endcase
  end

  // Final sum with saturation to the value range.
  always_comb begin
    sum = SW'(cur) + SW'(prod) + SW'(signed'({1'b0, low_part}));
    if (sum > Q_MAX) begin
      nv = VW'(Q_MAX);
    end else if (sum < Q_MIN) begin
      nv = VW'(Q_MIN);
    end else begin
      nv = VW'(sum);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and table port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    wr_addr    = q_addr;
    wr_data    = nv;
    rd_addr    = ((cmd == CMD_UPDATE) ? next_base : cur_base) + AW'(k);
    case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == AW'(Q_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (item_bad || ((cmd == CMD_CHOOSE) && cur_flags.full)) begin
          state_next = S_RESULT;
        end else if (cmd == CMD_CHOOSE) begin
          state_next = S_DRAW;
        end else begin
          state_next = S_READ;
        end
      end
      S_DRAW: begin
        if ({1'b0, lfsr} < explore_threshold) begin
          state_next = S_MOD;
        end else begin
          state_next = S_READ;
        end
      end
      S_MOD: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = free[rem] ? S_RESULT : S_MOD;
      end
      S_READ: begin
        if (k == KW'(BOARD_CELLS)) begin
          rd_addr    = cur_base + AW'(act_sat);
          state_next = (cmd == CMD_UPDATE) ? S_CUR : S_RESULT;
        end
      end
      S_CUR:   state_next = S_INNER;
      S_INNER: state_next = S_MLO;
      S_MLO:   state_next = S_MHI;
      S_MHI:   state_next = S_SUM;
      S_SUM: begin
        mem_we     = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[wr_addr] <= wr_data;
    end
    rd_q <= qmem[rd_addr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate        <= LEARN_RATE_RESET;
      discount          <= DISCOUNT_RESET;
      explore_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEARN_RATE: learn_rate        <= cfg_data[RATE_W-1:0];
        CFG_DISCOUNT:   discount          <= cfg_data[RATE_W-1:0];
        CFG_THRESHOLD:  explore_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control registers: sweep address and random source
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      lfsr     <= LFSR_SEED;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if ((state == S_DECODE && cmd == CMD_CHOOSE && !item_bad && !cur_flags.full) ||
          (state == S_DRAW && {1'b0, lfsr} < explore_threshold) ||
          (state == S_PICK && !free[rem])) begin
        lfsr <= lfsr_step(lfsr);
      end
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd        <= s_axis_tuser;
          board      <= s_axis_tdata[17:0];
          act        <= s_axis_tdata[21:18];
          reward     <= s_axis_tdata[37:22];
          next_board <= s_axis_tdata[55:38];
        end
      end
      S_DECODE: begin
        cur_base     <= dec_cur_base;
        next_base    <= dec_next_base;
        k            <= '0;
        rd_live      <= 1'b0;
        have         <= 1'b0;
        res_action   <= '0;
        res_valid    <= 1'b0;
        res_explored <= 1'b0;
        res_value    <= '0;
        if (item_bad) begin
          res_status <= ST_BAD_CELL;
        end else if ((cmd == CMD_CHOOSE) && cur_flags.full) begin
          res_status <= ST_NO_FREE;
        end else begin
          res_status <= ST_OK;
        end
      end
      S_MOD: begin
        quo <= recip_prod[RPW-1:RECIP_SH];
      end
      S_PICK: begin
        if (free[rem]) begin
          res_action   <= 4'(rem);
          res_valid    <= 1'b1;
          res_explored <= 1'b1;
        end
      end
      S_READ: begin
        if (take) begin
          best <= rd_q;
          pick <= ridx;
          have <= 1'b1;
        end
        rd_live <= 1'b1;
        ridx    <= k[CW-1:0];
        k       <= k + KW'(1);
        if (k == KW'(BOARD_CELLS)) begin
          q_addr <= cur_base + AW'(act_sat);
          if (cmd == CMD_CHOOSE) begin
            res_action <= 4'(pick_c);
            res_valid  <= 1'b1;
          end
        end
      end
      S_CUR: begin
        cur  <= rd_q;
        prod <= PW'(signed'({1'b0, mul_a})) * PW'(mul_b);
      end
      S_INNER: begin
        inner <= (IW'(reward) <<< FRAC_BITS) + IW'(prod) - (IW'(cur) <<< FRAC_BITS);
      end
      S_MLO: begin
        prod <= PW'(signed'({1'b0, mul_a})) * PW'(mul_b);
      end
      S_MHI: begin
        // Low partial product contributes only its bits above the binary point.
        low_part <= prod[2*FRAC_BITS +: RATE_W];
        prod     <= PW'(signed'({1'b0, mul_a})) * PW'(mul_b);
      end
      S_SUM: begin
        res_value <= 16'(nv);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'd0, res_value, res_action};
      m_axis_tuser <= {res_status, res_explored, res_valid};
    end
  end

  // Checks
  `TQLE_ASSERT_SAME(a_no_accept_in_sweep, clk, rst, state == S_CLEAR,
    !s_axis_tready, "command accepted during table sweep")
  `TQLE_ASSERT_SAME(a_write_states, clk, rst, mem_we,
    state == S_CLEAR || state == S_SUM, "table written outside sweep or write-back")
  `TQLE_ASSERT_SAME(a_error_fields_zero, clk, rst,
    m_axis_tvalid && m_axis_tuser[3:2] != ST_OK,
    m_axis_tuser[1:0] == 2'b00 && m_axis_tdata[19:0] == 20'd0,
    "error result carries nonzero fields")
  `TQLE_ASSERT_SAME(a_choice_in_range, clk, rst, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[3:0] < 4'(BOARD_CELLS), "chosen action outside the board")
  `TQLE_ASSERT_NEXT(a_writeback_to_result, clk, rst, state == S_SUM,
    state == S_RESULT && lfsr != 16'd0, "write-back not followed by result")

endmodule
